/* rtl/jsu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, character codes and helper functions shared by the JSON string
// unescaper modules.
// ----------------------------------------------------------------------------
package jsu_pkg;

   typedef enum logic [3:0] {
      ERR_NONE         = 4'd0,
      ERR_NO_QUOTE     = 4'd1,
      ERR_CONTROL      = 4'd2,
      ERR_CUT_ESCAPE   = 4'd3,
      ERR_SHORT_U      = 4'd4,
      ERR_BAD_HEX      = 4'd5,
      ERR_BAD_HEX2     = 4'd6,
      ERR_BAD_LOW      = 4'd7,
      ERR_MISSING_LOW  = 4'd8,
      ERR_LONE_LOW     = 4'd9,
      ERR_UNKNOWN_ESC  = 4'd10,
      ERR_UNTERMINATED = 4'd11
   } error_type;

   typedef struct packed {
      logic        is_end;
      error_type   code;
      logic [1:0]  len_m1;
      logic [20:0] cp;
   } cmd_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_B         = 8'h62;
   localparam logic [7:0] CHAR_F         = 8'h66;
   localparam logic [7:0] CHAR_N         = 8'h6E;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_U         = 8'h75;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CODE_BS        = 8'h08;
   localparam logic [7:0] CODE_FF        = 8'h0C;
   localparam logic [7:0] CODE_LF        = 8'h0A;

   localparam logic [15:0] HIGH_SURR_MIN = 16'hD800;
   localparam logic [15:0] HIGH_SURR_MAX = 16'hDBFF;
   localparam logic [15:0] LOW_SURR_MIN  = 16'hDC00;
   localparam logic [15:0] LOW_SURR_MAX  = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE     = 21'h10000;

   localparam logic [20:0] MAX_ONE_BYTE   = 21'h00007F;
   localparam logic [20:0] MAX_TWO_BYTE   = 21'h0007FF;
   localparam logic [20:0] MAX_THREE_BYTE = 21'h00FFFF;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type r;
      r.ok  = 1'b1;
      r.val = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.val = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r.val = c[3:0] + 4'd9;
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [1:0] utf8_len_m1(input logic [20:0] cp);
      logic [1:0] r;
      if (cp <= MAX_ONE_BYTE) begin
         r = 2'd0;
      end else if (cp <= MAX_TWO_BYTE) begin
         r = 2'd1;
      end else if (cp <= MAX_THREE_BYTE) begin
         r = 2'd2;
      end else begin
         r = 2'd3;
      end
      return r;
   endfunction

endpackage

/* rtl/json_string_unescape_utf8.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Unescapes a JSON string literal from a byte stream and delivers its value
// as UTF-8 bytes, followed by one item that closes the string or reports an
// error.
//
//   Channel   Ports                               Handshake
//   input     req_text_byte, req_end_of_text      req_push / req_full
//   result    rsp_out_byte, rsp_byte_valid,       rsp_pop / rsp_empty
//             rsp_finished, rsp_error_code,
//             rsp_last
//
// The parser takes one input item per cycle while the command queue has
// room. The encoder drains one result item per cycle while the result
// stage is free, so a command of N UTF-8 bytes stays at the queue head
// until its last byte is taken. Results come from a registered stage. Reset
// clears the parser state, the queue and the result stage. A stall on the
// result side fills the queue of QUEUE_DEPTH commands before req_full rises.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_text_byte,
   input  logic       req_end_of_text,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_finished,
   output logic [3:0] rsp_error_code,
   output logic       rsp_last
);
   import jsu_pkg::*;

   logic    accept;
   logic    cmd_valid;
   cmd_type cmd;
   cmd_type head;
   logic    q_empty;
   logic    q_pop;

   assign accept = req_push && !req_full;

   jsu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .text_byte   (req_text_byte),
      .end_of_text (req_end_of_text),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd)
   );

   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_valid),
      .push_cmd (cmd),
      .full     (req_full),
      .pop      (q_pop),
      .head     (head),
      .empty    (q_empty)
   );

   jsu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_finished   (rsp_finished),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last)
   );

endmodule

/* rtl/jsu_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_front
// Parses one accepted text item per cycle, tracks the string and escape
// state, and turns each item into at most one command: a code point to
// encode or the end of a string with its status.
// ----------------------------------------------------------------------------
module jsu_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       text_byte,
   input  logic             end_of_text,
   output logic             cmd_valid,
   output jsu_pkg::cmd_type cmd
);
   import jsu_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_STR     = 3'd1,
      PH_ESC     = 3'd2,
      PH_HEX1    = 3'd3,
      PH_PAIR_BS = 3'd4,
      PH_PAIR_U  = 3'd5,
      PH_HEX2    = 3'd6
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] first_ff, first_in;
   logic [15:0] second_ff, second_in;
   logic [1:0]  count_ff, count_in;

   logic        emit;
   logic        end_hit;
   error_type   end_code;
   logic [20:0] data_cp;
   hex_type     hx;
   logic [15:0] new_first;
   logic [15:0] new_second;

   always_comb begin
      hx         = hex_decode(text_byte);
      new_first  = {first_ff[11:0], hx.val};
      new_second = {second_ff[11:0], hx.val};
      phase_in   = phase_ff;
      first_in   = first_ff;
      second_in  = second_ff;
      count_in   = count_ff;
      emit       = 1'b0;
      end_hit    = 1'b0;
      end_code   = ERR_NONE;
      data_cp    = 21'd0;
      case (phase_ff)
         PH_STR: begin
            if (end_of_text) begin
               end_hit  = 1'b1;
               end_code = ERR_UNTERMINATED;
            end else if (text_byte == CHAR_QUOTE) begin
               end_hit  = 1'b1;
               end_code = ERR_NONE;
            end else if (text_byte < CHAR_SPACE) begin
               end_hit  = 1'b1;
               end_code = ERR_CONTROL;
            end else if (text_byte == CHAR_BACKSLASH) begin
               phase_in = PH_ESC;
            end else begin
               emit    = 1'b1;
               data_cp = {13'd0, text_byte};
            end
         end
         PH_ESC: begin
            if (end_of_text) begin
               end_hit  = 1'b1;
               end_code = ERR_CUT_ESCAPE;
            end else begin
               phase_in = PH_STR;
               case (text_byte)
                  CHAR_QUOTE, CHAR_BACKSLASH, CHAR_SLASH: begin
                     emit    = 1'b1;
                     data_cp = {13'd0, text_byte};
                  end
                  CHAR_B: begin
                     emit    = 1'b1;
                     data_cp = {13'd0, CODE_BS};
                  end
                  CHAR_F: begin
                     emit    = 1'b1;
                     data_cp = {13'd0, CODE_FF};
                  end
                  CHAR_N: begin
                     emit    = 1'b1;
                     data_cp = {13'd0, CODE_LF};
                  end
                  CHAR_R: begin
                     emit    = 1'b1;
                     data_cp = {13'd0, CHAR_CR};
                  end
                  CHAR_T: begin
                     emit    = 1'b1;
                     data_cp = {13'd0, CHAR_TAB};
                  end
                  CHAR_U: begin
                     phase_in = PH_HEX1;
                     first_in = 16'd0;
                     count_in = 2'd0;
                  end
                  default: begin
                     end_hit  = 1'b1;
                     end_code = ERR_UNKNOWN_ESC;
                  end
               endcase
            end
         end
         PH_HEX1: begin
            if (end_of_text) begin
               end_hit  = 1'b1;
               end_code = ERR_SHORT_U;
            end else if (!hx.ok) begin
               end_hit  = 1'b1;
               end_code = ERR_BAD_HEX;
            end else begin
               first_in = new_first;
               if (count_ff == 2'd3) begin
                  count_in = 2'd0;
                  if (new_first >= HIGH_SURR_MIN && new_first <= HIGH_SURR_MAX) begin
                     phase_in = PH_PAIR_BS;
                  end else if (new_first >= LOW_SURR_MIN && new_first <= LOW_SURR_MAX) begin
                     end_hit  = 1'b1;
                     end_code = ERR_LONE_LOW;
                  end else begin
                     phase_in = PH_STR;
                     emit     = 1'b1;
                     data_cp  = {5'd0, new_first};
                  end
               end else begin
                  count_in = count_ff + 2'd1;
               end
            end
         end
         PH_PAIR_BS: begin
            if (end_of_text || text_byte != CHAR_BACKSLASH) begin
               end_hit  = 1'b1;
               end_code = ERR_MISSING_LOW;
            end else begin
               phase_in = PH_PAIR_U;
            end
         end
         PH_PAIR_U: begin
            if (end_of_text || text_byte != CHAR_U) begin
               end_hit  = 1'b1;
               end_code = ERR_MISSING_LOW;
            end else begin
               phase_in  = PH_HEX2;
               second_in = 16'd0;
               count_in  = 2'd0;
            end
         end
         PH_HEX2: begin
            if (end_of_text) begin
               end_hit  = 1'b1;
               end_code = ERR_MISSING_LOW;
            end else if (!hx.ok) begin
               end_hit  = 1'b1;
               end_code = ERR_BAD_HEX2;
            end else begin
               second_in = new_second;
               if (count_ff == 2'd3) begin
                  count_in = 2'd0;
                  if (new_second < LOW_SURR_MIN || new_second > LOW_SURR_MAX) begin
                     end_hit  = 1'b1;
                     end_code = ERR_BAD_LOW;
                  end else begin
                     phase_in = PH_STR;
                     emit     = 1'b1;
                     data_cp  = SUPP_BASE + {1'b0, first_ff[9:0], new_second[9:0]};
                  end
               end else begin
                  count_in = count_ff + 2'd1;
               end
            end
         end
         default: begin
            if (end_of_text) begin
               end_hit  = 1'b1;
               end_code = ERR_NO_QUOTE;
            end else if (text_byte == CHAR_SPACE ||
                         (text_byte >= CHAR_TAB && text_byte <= CHAR_CR)) begin
               phase_in = PH_IDLE;
            end else if (text_byte == CHAR_QUOTE) begin
               phase_in = PH_STR;
            end else begin
               end_hit  = 1'b1;
               end_code = ERR_NO_QUOTE;
            end
         end
      endcase
      if (end_hit) begin
         emit     = 1'b1;
         phase_in = PH_IDLE;
         count_in = 2'd0;
      end
   end

   always_comb begin
      cmd.is_end = end_hit;
      cmd.code   = end_code;
      cmd.cp     = data_cp;
      cmd.len_m1 = utf8_len_m1(data_cp);
      cmd_valid  = accept & emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         first_ff  <= 16'd0;
         second_ff <= 16'd0;
         count_ff  <= 2'd0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/jsu_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_queue
// Small first-in first-out queue of commands between the parser and the
// UTF-8 encoder.
// ----------------------------------------------------------------------------
module jsu_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jsu_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output jsu_pkg::cmd_type head,
   output logic             empty
);
   import jsu_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   cmd_type            store_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   always_comb begin
      full    = (count_ff == FULL_CNT);
      empty   = (count_ff == '0);
      head    = store_ff[rd_ptr_ff];
      do_push = push && !full;
      do_pop  = pop && !empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/jsu_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_back
// Encodes the command at the queue head as UTF-8, or reports the end of a
// string, into a registered result stage, one byte per cycle while it is free.
// ----------------------------------------------------------------------------
module jsu_back (
   input  logic             clock,
   input  logic             reset,
   input  jsu_pkg::cmd_type head,
   input  logic             q_empty,
   output logic             q_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_byte_valid,
   output logic             rsp_finished,
   output logic [3:0]       rsp_error_code,
   output logic             rsp_last
);
   import jsu_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic [1:0] idx_ff, idx_in;
   logic [7:0] byte_ff;
   logic       byte_valid_ff;
   logic       finished_ff;
   error_type  code_ff;
   logic       last_ff;

   logic       slot_free;
   logic       take;
   logic       final_byte;
   logic [1:0] group;
   logic [7:0] enc_byte;

   always_comb begin
      slot_free  = !out_valid_ff || rsp_pop;
      take       = slot_free && !q_empty;
      final_byte = head.is_end || (idx_ff == head.len_m1);
      q_pop      = take && final_byte;
      group      = head.len_m1 - idx_ff;
      if (idx_ff == 2'd0) begin
         case (head.len_m1)
            2'd0:    enc_byte = head.cp[7:0];
            2'd1:    enc_byte = {3'b110, head.cp[10:6]};
            2'd2:    enc_byte = {4'b1110, head.cp[15:12]};
            default: enc_byte = {5'b11110, head.cp[20:18]};
         endcase
      end else begin
         case (group)
            2'd1:    enc_byte = {2'b10, head.cp[11:6]};
            2'd2:    enc_byte = {2'b10, head.cp[17:12]};
            default: enc_byte = {2'b10, head.cp[5:0]};
         endcase
      end
      idx_in = idx_ff;
      if (take) begin
         idx_in = final_byte ? 2'd0 : idx_ff + 2'd1;
      end
      out_valid_in = take ? 1'b1 : (rsp_pop ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff       <= head.is_end ? 8'd0 : enc_byte;
         byte_valid_ff <= !head.is_end;
         finished_ff   <= head.is_end;
         code_ff       <= head.is_end ? head.code : ERR_NONE;
         last_ff       <= final_byte;
      end
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_byte_valid = byte_valid_ff;
   assign rsp_finished   = finished_ff;
   assign rsp_error_code = code_ff;
   assign rsp_last       = last_ff;

endmodule
